// File: design/hcsd_pkg.sv
// Shared constants for the hash chain seed derivation unit.
`timescale 1ns / 1ps

package hcsd_pkg;

  // Number of 64-bit seed registers and their indexes.
  localparam int unsigned SeedWords = 4;
  localparam logic [1:0]  RegSeed0  = 2'd0;
  localparam logic [1:0]  RegSeed1  = 2'd1;
  localparam logic [1:0]  RegSeed2  = 2'd2;
  localparam logic [1:0]  RegSeed3  = 2'd3;

  // SHA-256 compression runs this many rounds.
  localparam int unsigned Rounds = 64;

  typedef logic [31:0] word_t;

  // Initial hash value.
  localparam word_t Iv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants.
  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Fixed padding words of a single 32-byte message block.
  localparam word_t PadWord  = 32'h80000000;
  localparam word_t LenWord  = 32'd256;

endpackage

// File: design/hash_chain_seed_derivation_unit.sv
// Top level of the hash chain seed derivation unit: sequencer and shared SHA-256 round unit.
`timescale 1ns / 1ps

// Usage: program the 256-bit seed through the APB port (four 64-bit registers at byte
// addresses 0, 8, 16 and 24; pready is always high, reads return the register). Then
// raise start_i with chain_index_i while busy_o is low; the request is taken at that
// edge and busy_o stays high until the result is ready.
// The unit walks the index bits from the top down, one bit per cycle unless a compression
// holds it. For each zero bit it flips the matching hash bit and runs one SHA-256
// compression on the shared round unit: a load step, the rounds and a final add.
// The result appears on hash_word_*_o, marked by done_o for a single cycle, and holds
// until the next request is taken; the receiver cannot stall it, and a new request may
// be taken in that same cycle, so the unit takes no new request before the last is served.
// Reset clears the seed registers to zero and returns the sequencer to idle.
module hash_chain_seed_derivation_unit
  import hcsd_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] chain_index_i,
  output logic        done_o,
  output logic [63:0] hash_word_0_o,
  output logic [63:0] hash_word_1_o,
  output logic [63:0] hash_word_2_o,
  output logic [63:0] hash_word_3_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned BitW = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StRound = 2'd2;
  localparam logic [1:0] StFinal = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [BitW-1:0]       bit_q, bit_d;
  logic [5:0]            rnd_q, rnd_d;
  logic                  done_q, done_d;
  logic [INDEX_BITS-1:0] idx_q;
  logic [63:0]           seed_q [SeedWords];
  logic [255:0]          hash_q;
  word_t                 v_q [8];
  word_t                 w_q [16];

  logic                  accept;
  logic                  cfg_wr;
  logic                  cur_zero;
  logic                  last_bit;
  logic [255:0]          flip_mask;
  logic [255:0]          flipped;
  logic [255:0]          digest;
  word_t                 t1, t2, s0e, s1a, ch, maj, w_new, ss0, ss1;

  assign accept   = start_i && (state_q == StIdle);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign busy_o   = (state_q != StIdle);
  assign done_o   = done_q;
  assign cur_zero = !idx_q[bit_q];
  assign last_bit = (bit_q == '0);

  // Register read-back.
  always_comb begin
    case (paddr[4:3])
      RegSeed0: prdata = seed_q[0];
      RegSeed1: prdata = seed_q[1];
      RegSeed2: prdata = seed_q[2];
      RegSeed3: prdata = seed_q[3];
      default:  prdata = '0;
    endcase
  end

  // Seed registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SeedWords; i++) seed_q[i] <= '0;
    end else if (cfg_wr) begin
      seed_q[paddr[4:3]] <= pwdata;
    end
  end

  // Hash bit flipped for the current index bit.
  assign flip_mask = 256'(1) << bit_q;
  assign flipped   = hash_q ^ flip_mask;

  // One SHA-256 round on the working variables.
  always_comb begin
    s0e = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
        ^ {v_q[4][24:0], v_q[4][31:25]};
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1  = v_q[7] + s0e + ch + RoundK[rnd_q] + w_q[0];
    s1a = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
        ^ {v_q[0][21:0], v_q[0][31:22]};
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2  = s1a + maj;
  end

  // Message schedule extension from the sixteen-word window.
  always_comb begin
    ss0   = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]}
          ^ {3'b000, w_q[1][31:3]};
    ss1   = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
          ^ {10'd0, w_q[14][31:10]};
    w_new = w_q[0] + ss0 + w_q[9] + ss1;
  end

  // Final add, repacked into byte order.
  always_comb begin
    word_t hw;
    digest = '0;
    for (int i = 0; i < 8; i++) begin
      hw = Iv[i] + v_q[i];
      digest[8*(4*i)   +: 8] = hw[31:24];
      digest[8*(4*i+1) +: 8] = hw[23:16];
      digest[8*(4*i+2) +: 8] = hw[15:8];
      digest[8*(4*i+3) +: 8] = hw[7:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    rnd_d   = rnd_q;
    done_d  = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StScan;
          bit_d   = BitW'(INDEX_BITS - 1);
        end
      end
      StScan: begin
        if (cur_zero) begin
          state_d = StRound;
          rnd_d   = '0;
        end else if (last_bit) begin
          state_d = StIdle;
          done_d  = 1'b1;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      StRound: begin
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == 6'(Rounds - 1)) state_d = StFinal;
      end
      StFinal: begin
        if (last_bit) begin
          state_d = StIdle;
          done_d  = 1'b1;
        end else begin
          state_d = StScan;
          bit_d   = bit_q - 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      bit_q   <= '0;
      rnd_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      rnd_q   <= rnd_d;
      done_q  <= done_d;
    end
  end

  // Datapath: index, running hash, working variables and schedule window.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (accept) begin
          idx_q  <= chain_index_i[INDEX_BITS-1:0];
          hash_q <= {seed_q[3], seed_q[2], seed_q[1], seed_q[0]};
        end
      end
      StScan: begin
        if (cur_zero) begin
          for (int i = 0; i < 8; i++) begin
            v_q[i] <= Iv[i];
            w_q[i] <= {flipped[8*(4*i) +: 8], flipped[8*(4*i+1) +: 8],
                       flipped[8*(4*i+2) +: 8], flipped[8*(4*i+3) +: 8]};
          end
          for (int i = 8; i < 15; i++) w_q[i] <= (i == 8) ? PadWord : '0;
          w_q[15] <= LenWord;
        end
      end
      StRound: begin
        v_q[7] <= v_q[6];
        v_q[6] <= v_q[5];
        v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2];
        v_q[2] <= v_q[1];
        v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= w_new;
      end
      StFinal: begin
        hash_q <= digest;
      end
      default: begin
      end
    endcase
  end

  assign hash_word_0_o = hash_q[63:0];
  assign hash_word_1_o = hash_q[127:64];
  assign hash_word_2_o = hash_q[191:128];
  assign hash_word_3_o = hash_q[255:192];

`ifndef SYNTHESIS
  // A result only follows a cycle of work.
  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == StScan || state_q == StFinal))
    else $error("result strobe without preceding work");

  // An accepted request makes the unit busy.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request accepted but unit not busy");

  // The last round is always followed by the final add.
  a_round_to_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound && rnd_q == 6'(Rounds - 1)) |=> (state_q == StFinal))
    else $error("compression did not end in the final add");
`endif

endmodule
